FILE: hw/rtl/csmv_pkg.sv
// csmv_pkg: word layout, field widths, accumulator types and saturation helpers
// for the chunked sparse matrix-vector block. Depends on nothing.

package csmv_pkg;

    // Chunk geometry and field widths
    localparam int LANES   = 4;
    localparam int XADDR_W = 10;
    localparam int VAL_W   = 32;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 16;

    // Input tdata layout, lowest bit first
    localparam int OFF_XADDR = 0;
    localparam int OFF_XVAL  = OFF_XADDR + XADDR_W;
    localparam int OFF_COL   = OFF_XVAL + VAL_W;
    localparam int OFF_VAL   = OFF_COL + LANES * COL_W;
    localparam int S_USED_W  = OFF_VAL + LANES * VAL_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int OFF_ROW   = 0;
    localparam int OFF_Y     = ROW_W;
    localparam int M_TDATA_W = ((ROW_W + VAL_W + 7) / 8) * 8;

    // Item kinds carried on tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHUNK = 1'b1;

    // Arithmetic widths: Q32.32 accumulator, chunk offset, one-add headroom
    localparam int ACC_W  = 64;
    localparam int CSUM_W = 66;
    localparam int WIDE_W = 67;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [CSUM_W-1:0] t_csum;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_val Y_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val Y_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

    // Clamp a widened sum to the signed 64-bit range
    function automatic t_acc f_sat64(input t_wide z);
        t_acc r;
        if (z > t_wide'(ACC_MAX)) begin
            r = ACC_MAX;
        end else if (z < t_wide'(ACC_MIN)) begin
            r = ACC_MIN;
        end else begin
            r = z[ACC_W-1:0];
        end
        return r;
    endfunction

    // Q32.32 to Q16.16: floor by dropping 16 bits, then saturate
    function automatic t_val f_reduce(input t_acc s);
        logic signed [ACC_W-17:0] q;
        t_val r;
        q = s[ACC_W-1:16];
        if (q > (ACC_W-16)'(Y_MAX)) begin
            r = Y_MAX;
        end else if (q < (ACC_W-16)'(Y_MIN)) begin
            r = Y_MIN;
        end else begin
            r = q[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/chunked_sparse_matvec.sv
// chunked_sparse_matvec: top level, vector store, lane multipliers and row accumulator.
// Depends on csmv_pkg.
//
//  channel   dir  tdata                                          tuser  tlast
//  s_axis    in   x_addr, x_value, col_a..col_d, val_a..val_d    cmd    row_end
//  m_axis    out  row_index, y_value                             -      -
//
// One word is taken per cycle while the input stage is free. A result leaves its closing
// chunk through, in order: store read, four multipliers, four lane steps that fold the
// chunk into a single offset and clamp window, one add and clamp in the accumulator
// loop, then the Q16.16 reduction. Loads write the store in the cycle they are taken.
// Stages only stall when the word ahead cannot move, so a waiting result blocks
// input only once the pipeline is full. Reset clears valids, sum and row count;
// the store holds no reset value.

module chunked_sparse_matvec #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int ROW_LIMIT    = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_axis tdata, lowest bit up: x_addr, x_value, col_a, col_b, col_c, col_d,
    // val_a, val_b, val_c, val_d, zero fill
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [csmv_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // s_axis tuser: cmd
    input  logic [0:0]                    i_s_axis_tuser,
    // s_axis tlast: row_end
    input  logic                          i_s_axis_tlast,
    // m_axis tdata, lowest bit up: row_index, y_value
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [csmv_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import csmv_pkg::*;

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int RW = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;

    // Reduce a 10-bit index modulo the store depth by constant compare-subtract steps
    function automatic logic [XADDR_W-1:0] f_wrap(input logic [XADDR_W-1:0] v);
        logic [XADDR_W-1:0] t;
        t = v;
        for (int i = XADDR_W - 1; i >= 0; i--) begin
            if ((VECTOR_DEPTH << i) < (1 << XADDR_W)) begin
                if (t >= XADDR_W'(VECTOR_DEPTH << i)) begin
                    t = t - XADDR_W'(VECTOR_DEPTH << i);
                end
            end
        end
        return t;
    endfunction

    // Input unpacking
    logic                 w_in_fire;
    logic                 w_is_chunk;
    logic [AW-1:0]        w_xaddr;
    logic [AW-1:0]        w_raddr [LANES];
    logic [COL_W-1:0]     w_col   [LANES];
    t_val                 w_val   [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_col[k]   = i_s_axis_tdata[OFF_COL + k*COL_W +: COL_W];
            w_val[k]   = i_s_axis_tdata[OFF_VAL + k*VAL_W +: VAL_W];
            w_raddr[k] = AW'(f_wrap(w_col[k][XADDR_W-1:0]));
        end
    end

    assign w_xaddr    = AW'(f_wrap(i_s_axis_tdata[OFF_XADDR +: XADDR_W]));
    assign w_is_chunk = (i_s_axis_tuser[0] == CMD_CHUNK);

    // Stall chain
    logic r_s1_v;
    logic r_s1_end;
    logic r_pv  [LANES+1];
    logic r_pe  [LANES+1];
    logic r_as_v;
    logic r_out_v;

    logic w_out_free;
    logic w_as_free;
    logic w_free    [LANES+1];
    logic w_s1_free;
    logic w_acc_fire;

    assign w_out_free = !r_out_v || i_m_axis_tready;
    assign w_as_free  = !r_as_v || w_out_free;

    always_comb begin
        w_free[LANES] = !r_pv[LANES] || !r_pe[LANES] || w_as_free;
        for (int k = LANES - 1; k >= 0; k--) begin
            w_free[k] = !r_pv[k] || w_free[k+1];
        end
    end

    assign w_s1_free       = !r_s1_v || w_free[0];
    assign o_s_axis_tready = w_s1_free;
    assign w_in_fire       = i_s_axis_tvalid && w_s1_free;
    assign w_acc_fire      = r_pv[LANES] && w_free[LANES];

    // Vector store: two copies, each read at two lane addresses
    logic [VAL_W-1:0] r_mem_a [VECTOR_DEPTH];
    logic [VAL_W-1:0] r_mem_b [VECTOR_DEPTH];
    t_val             r_xv    [LANES];
    t_val             r_s1_val [LANES];
    logic             r_s1_pad [LANES];

    always_ff @(posedge i_clk) begin
        if (w_in_fire && !w_is_chunk) begin
            r_mem_a[w_xaddr] <= i_s_axis_tdata[OFF_XVAL +: VAL_W];
            r_mem_b[w_xaddr] <= i_s_axis_tdata[OFF_XVAL +: VAL_W];
        end
        if (w_s1_free) begin
            r_xv[0] <= r_mem_a[w_raddr[0]];
            r_xv[1] <= r_mem_a[w_raddr[1]];
            r_xv[2] <= r_mem_b[w_raddr[2]];
            r_xv[3] <= r_mem_b[w_raddr[3]];
            for (int k = 0; k < LANES; k++) begin
                r_s1_val[k] <= w_val[k];
                r_s1_pad[k] <= w_col[k][COL_W-1];
            end
            r_s1_end <= i_s_axis_tlast;
        end
    end

    // Products and lane fold: each chunk becomes sum = clamp(sum + c, lo, hi)
    t_acc  r_pp [LANES+1][LANES];
    t_csum r_pc [LANES+1];
    t_acc  r_pl [LANES+1];
    t_acc  r_ph [LANES+1];

    always_ff @(posedge i_clk) begin
        // multiply stage, pad lanes add zero
        if (w_free[0]) begin
            for (int k = 0; k < LANES; k++) begin
                r_pp[0][k] <= r_s1_pad[k] ? '0 : (t_acc'(r_xv[k]) * t_acc'(r_s1_val[k]));
            end
            r_pc[0] <= '0;
            r_pl[0] <= ACC_MIN;
            r_ph[0] <= ACC_MAX;
            r_pe[0] <= r_s1_end;
        end
        // one lane folded per stage, in lane order
        for (int j = 0; j < LANES; j++) begin
            if (w_free[j+1]) begin
                r_pp[j+1] <= r_pp[j];
                r_pc[j+1] <= r_pc[j] + t_csum'(r_pp[j][j]);
                r_pl[j+1] <= f_sat64(t_wide'(r_pl[j]) + t_wide'(r_pp[j][j]));
                r_ph[j+1] <= f_sat64(t_wide'(r_ph[j]) + t_wide'(r_pp[j][j]));
                r_pe[j+1] <= r_pe[j];
            end
        end
    end

    // Accumulator loop: one add and a clamp to the folded window
    t_acc          r_acc;
    logic [RW-1:0] r_row;
    t_acc          r_as_sum;
    logic [RW-1:0] r_as_row;
    t_wide         w_z;
    t_acc          w_sum;

    always_comb begin
        w_z = t_wide'(r_acc) + t_wide'(r_pc[LANES]);
        if (w_z < t_wide'(r_pl[LANES])) begin
            w_sum = r_pl[LANES];
        end else if (w_z > t_wide'(r_ph[LANES])) begin
            w_sum = r_ph[LANES];
        end else begin
            w_sum = w_z[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_fire && r_pe[LANES]) begin
            r_as_sum <= w_sum;
            r_as_row <= r_row;
        end
    end

    // Output register
    t_val             r_out_y;
    logic [ROW_W-1:0] r_out_row;

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_y   <= f_reduce(r_as_sum);
            r_out_row <= ROW_W'(r_as_row);
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_y, r_out_row});

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_as_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_acc   <= '0;
            r_row   <= '0;
            for (int k = 0; k <= LANES; k++) begin
                r_pv[k] <= 1'b0;
            end
        end else begin
            if (w_s1_free) begin
                r_s1_v <= i_s_axis_tvalid && w_is_chunk;
            end
            if (w_free[0]) begin
                r_pv[0] <= r_s1_v;
            end
            for (int j = 0; j < LANES; j++) begin
                if (w_free[j+1]) begin
                    r_pv[j+1] <= r_pv[j];
                end
            end
            if (w_acc_fire) begin
                if (r_pe[LANES]) begin
                    r_acc <= '0;
                    r_row <= (r_row == RW'(ROW_LIMIT - 1)) ? '0 : r_row + 1'b1;
                end else begin
                    r_acc <= w_sum;
                end
            end
            if (w_as_free) begin
                r_as_v <= w_acc_fire && r_pe[LANES];
            end
            if (w_out_free) begin
                r_out_v <= r_as_v;
            end
        end
    end

endmodule

FILE: test/matvec_checker.sv
// matvec_checker: watches both stream channels of chunked_sparse_matvec, predicts every
// row result from the accepted words and compares the results in order.
// Depends on csmv_pkg.
`timescale 1ns / 1ps

module matvec_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // tdata, lowest bit up: x_addr, x_value, col_a..col_d, val_a..val_d, zero fill
    input  logic [csmv_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: cmd
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // tdata, lowest bit up: row_index, y_value
    input  logic [csmv_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    import csmv_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        t_val             y;
    } t_row_result;

    localparam logic signed [ACC_W+1:0] SUM_HI = (66'sd1 <<< 63) - 66'sd1;
    localparam logic signed [ACC_W+1:0] SUM_LO = -(66'sd1 <<< 63);

    // Shadow of the block state
    t_val             x_store [1 << XADDR_W];
    t_acc             row_acc;
    logic [ROW_W-1:0] row_num;
    t_row_result      row_results [$];
    int               fails;

    // One lane: full-precision product added with clamp at the 64-bit bounds
    function automatic t_acc mac_clamped(input t_acc acc, input t_val a, input t_val b);
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W+1:0] wide;
        prod = t_acc'(a) * t_acc'(b);
        wide = (ACC_W+2)'(acc) + (ACC_W+2)'(prod);
        if (wide > SUM_HI) begin
            return ACC_MAX;
        end else if (wide < SUM_LO) begin
            return ACC_MIN;
        end
        return wide[ACC_W-1:0];
    endfunction

    // Q32.32 to Q16.16: floor, then clamp to 32 bits
    function automatic t_val row_to_q16(input t_acc acc);
        logic signed [ACC_W-17:0] q;
        q = (ACC_W-16)'(acc >>> 16);
        if (q > 48'sd2147483647) begin
            return Y_MAX;
        end else if (q < -48'sd2147483648) begin
            return Y_MIN;
        end
        return q[VAL_W-1:0];
    endfunction

    // Fold one accepted word into the shadow state
    task automatic absorb_word(input logic cmd, input logic [S_TDATA_W-1:0] data,
                               input logic last);
        logic [COL_W-1:0] col;
        t_row_result      res;
        if (cmd == CMD_LOAD) begin
            x_store[data[OFF_XADDR +: XADDR_W]] = data[OFF_XVAL +: VAL_W];
        end else begin
            for (int k = 0; k < LANES; k++) begin
                col = data[OFF_COL + k * COL_W +: COL_W];
                // any negative column is padding
                if (!col[COL_W-1]) begin
                    row_acc = mac_clamped(row_acc, data[OFF_VAL + k * VAL_W +: VAL_W],
                                          x_store[col[XADDR_W-1:0]]);
                end
            end
            if (last) begin
                res.row = row_num;
                res.y = row_to_q16(row_acc);
                row_results.push_back(res);
                row_acc = '0;
                row_num = row_num + 1'b1;
            end
        end
    endtask

    task automatic note_failure();
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_row_result got;
        t_row_result want;
        if (!i_rst_n) begin
            row_acc = '0;
            row_num = '0;
            row_results.delete();
        end else begin
            // results first, then the word taken at this edge
            if (i_m_tvalid && i_m_tready) begin
                got.row = i_m_tdata[OFF_ROW +: ROW_W];
                got.y = i_m_tdata[OFF_Y +: VAL_W];
                if (row_results.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected result: row %0d y %h", got.row, got.y);
                    end
                    note_failure();
                end else begin
                    want = row_results.pop_front();
                    if (got != want) begin
                        if (fails < 10) begin
                            $display("mismatch: expected row %0d y %h, got row %0d y %h",
                                     want.row, want.y, got.row, got.y);
                        end
                        note_failure();
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_word(i_s_tuser[0], i_s_tdata, i_s_tlast);
            end
        end
        o_fail_count <= fails;
        o_pending <= row_results.size();
    end

endmodule

FILE: test/chunked_sparse_matvec_test.sv
// chunked_sparse_matvec_test: stimulus, idling and verdict for chunked_sparse_matvec.
// Depends on csmv_pkg, chunked_sparse_matvec and matvec_checker.
`timescale 1ns / 1ps

module chunked_sparse_matvec_test;

    import csmv_pkg::*;

    typedef logic [LANES-1:0][COL_W-1:0] t_lane_cols;
    typedef logic [LANES-1:0][VAL_W-1:0] t_lane_vals;

    localparam logic [COL_W-1:0] PAD       = '1;
    localparam t_val             ONE       = 32'h0001_0000;
    localparam t_val             MINUS_ONE = 32'hFFFF_0000;
    localparam int               HOLD_CYCLES = 400;
    localparam int               RANDOM_PER_PHASE = 260;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // tdata, lowest bit up: x_addr, x_value, col_a..col_d, val_a..val_d, zero fill
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // tuser: cmd
    logic [0:0]           s_tuser = CMD_LOAD;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // tdata, lowest bit up: row_index, y_value
    logic [M_TDATA_W-1:0] m_tdata;

    int                   send_idle = 0;
    int                   recv_idle = 0;
    bit                   hold_req = 1'b0;
    int                   fail_count;
    int                   pending;
    bit                   x_written [1 << XADDR_W];
    logic [XADDR_W-1:0]   written_addrs [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    chunked_sparse_matvec dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    matvec_checker u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus one long hold-off counted here
    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic set_idle(input int snd, input int rcv);
        send_idle = snd;
        recv_idle <= rcv;
    endtask

    function automatic logic [S_TDATA_W-1:0] pack_word(input logic [XADDR_W-1:0] xaddr,
                                                       input t_val xval,
                                                       input t_lane_cols cols,
                                                       input t_lane_vals vals);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[OFF_XADDR +: XADDR_W] = xaddr;
        data[OFF_XVAL +: VAL_W] = xval;
        data[OFF_COL +: LANES * COL_W] = cols;
        data[OFF_VAL +: LANES * VAL_W] = vals;
        return data;
    endfunction

    // Offer one word after a random gap; returns at the edge that takes it
    task automatic send_word(input logic cmd, input logic [S_TDATA_W-1:0] data,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Vector load; lane fields and tlast carry junk the block must ignore
    task automatic load_x(input logic [XADDR_W-1:0] addr, input t_val value);
        if (!x_written[addr]) begin
            x_written[addr] = 1'b1;
            written_addrs.push_back(addr);
        end
        send_word(CMD_LOAD,
                  pack_word(addr, value, t_lane_cols'({$urandom, $urandom}),
                            {$urandom, $urandom, $urandom, $urandom}),
                  1'($urandom_range(0, 1)));
    endtask

    // Matrix chunk; the vector fields carry junk
    task automatic send_chunk(input t_lane_cols cols, input t_lane_vals vals,
                              input logic last);
        send_word(CMD_CHUNK, pack_word(XADDR_W'($urandom), $urandom, cols, vals), last);
    endtask

    function automatic t_val random_value();
        case ($urandom_range(0, 9))
            0: return Y_MAX;
            1: return Y_MIN;
            2, 3, 4: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
            default: return $urandom;
        endcase
    endfunction

    // Padding is any negative column, mostly -1
    function automatic logic [COL_W-1:0] random_pad();
        if ($urandom_range(0, 1) != 0) begin
            return PAD;
        end
        return {1'b1, XADDR_W'($urandom)};
    endfunction

    // Chunk reading only vector entries already written
    task automatic random_chunk(input logic last);
        t_lane_cols cols;
        t_lane_vals vals;
        bit         all_pad;
        all_pad = ($urandom_range(0, 99) < 5);
        for (int k = 0; k < LANES; k++) begin
            if (all_pad || $urandom_range(0, 99) < 20) begin
                cols[k] = random_pad();
            end else begin
                cols[k] = {1'b0, written_addrs[$urandom_range(0, written_addrs.size() - 1)]};
            end
            vals[k] = random_value();
        end
        send_chunk(cols, vals, last);
    endtask

    task automatic random_word();
        if ($urandom_range(0, 99) < 20) begin
            load_x(XADDR_W'($urandom), random_value());
        end else begin
            random_chunk($urandom_range(0, 99) < 30);
        end
    endtask

    // Stop offering and wait for every predicted row to come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: light sender gaps, heavy result stalls
        set_idle(8, 65);

        // Vector extremes and alternating address bits
        load_x(10'd0, Y_MAX);
        load_x(10'd1023, Y_MIN);
        load_x(10'd5, ONE);
        load_x(10'd682, MINUS_ONE);
        load_x(10'd341, 32'h0000_8000);
        load_x(10'd7, 32'h0000_0001);
        // lanes listed d, c, b, a: pads between live lanes, row stays open
        send_chunk({PAD, 11'd5, PAD, 11'd5}, {$urandom, 32'h0002_0000, $urandom, ONE}, 1'b0);
        // -1024 and -2 act as padding too; closes row 0
        send_chunk({11'd341, 11'h7FE, 11'd682, 11'h400},
                   {ONE, $urandom, 32'h0003_0000, $urandom}, 1'b1);
        // empty row
        send_chunk({LANES{PAD}}, {$urandom, $urandom, $urandom, $urandom}, 1'b1);
        // accumulator clamps high, then low
        send_chunk({LANES{11'd1023}}, {LANES{Y_MIN}}, 1'b1);
        send_chunk({LANES{11'd0}}, {LANES{Y_MIN}}, 1'b1);
        // clamp high mid-row, then pulled back down by a later chunk
        send_chunk({LANES{11'd1023}}, {LANES{Y_MIN}}, 1'b0);
        send_chunk({PAD, PAD, PAD, 11'd0}, {$urandom, $urandom, $urandom, Y_MIN}, 1'b1);
        // -2^-32 floors to -2^-16
        send_chunk({PAD, PAD, PAD, 11'd7}, {$urandom, $urandom, $urandom, 32'hFFFF_FFFF}, 1'b1);
        // all-pad chunk inside a row changes nothing
        send_chunk({LANES{PAD}}, {$urandom, $urandom, $urandom, $urandom}, 1'b0);
        send_chunk({11'd682, 11'd5, 11'd0, 11'd1023},
                   {$urandom, $urandom, $urandom, $urandom}, 1'b0);
        send_chunk({LANES{PAD}}, {$urandom, $urandom, $urandom, $urandom}, 1'b1);
        // a load in mid-row leaves the running sum alone
        send_chunk({PAD, PAD, PAD, 11'd5}, {$urandom, $urandom, $urandom, ONE}, 1'b0);
        load_x(10'd5, random_value());
        send_chunk({PAD, PAD, PAD, 11'd5}, {$urandom, $urandom, $urandom, ONE}, 1'b1);

        repeat (RANDOM_PER_PHASE) random_word();

        // Long result hold-off while rows keep arriving, so the input backs up
        hold_req <= 1'b1;
        set_idle(0, 65);
        repeat (40) random_chunk(1'b1);
        wait_drained();

        // Phase 2: heavy sender gaps, light result stalls
        set_idle(65, 8);
        repeat (RANDOM_PER_PHASE) random_word();
        wait_drained();

        // Phase 3: no idling on either side
        set_idle(0, 0);
        repeat (RANDOM_PER_PHASE) random_word();
        repeat (20) random_word();

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
